// File: sv/pls_pkg.sv
// ============================================================================
// pls_pkg
// Shared constants and types of the particle life shader.
// ============================================================================
package pls_pkg;

    localparam int PLS_DIV_W   = 17;   // divider numerator/denominator width
    localparam int PLS_Q_W     = 16;   // divider quotient width (fraction bits)
    localparam int PLS_DIV_BPS = 2;    // quotient bits resolved per divider stage

    localparam logic [16:0] PLS_ONE     = 17'h10000;
    localparam logic [24:0] PLS_RCP255  = 25'd16843010;   // ceil(2^32 / 255)

    localparam logic [31:0] PLS_RST_BASE  = 32'hFFFF_FFFF;
    localparam logic [31:0] PLS_RST_FADE  = 32'hFFFF_0000;
    localparam logic [32:0] PLS_RST_TEX   = 33'h1_0000_0000;

    typedef enum logic [2:0] {
        CFG_BASE_COLOR   = 3'd0,
        CFG_STOP_FIRST   = 3'd1,
        CFG_STOP_MIDDLE  = 3'd2,
        CFG_STOP_LAST    = 3'd3,
        CFG_FADE_KEYS    = 3'd4,
        CFG_STOP_KEYS    = 3'd5,
        CFG_TEX_SETUP    = 3'd6,
        CFG_MODE_BITS    = 3'd7
    } t_cfg_idx;

endpackage

// File: sv/pls_in_if.sv
// ============================================================================
// pls_in_if
// Particle input channel: valid/ready with age, life and birth size.
// ============================================================================
interface pls_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] age_ticks;
    logic [15:0] life_ticks;
    logic [15:0] birth_size;

    modport source (output valid, output age_ticks, output life_ticks,
                    output birth_size, input ready);
    modport sink   (input valid, input age_ticks, input life_ticks,
                    input birth_size, output ready);
endinterface

// File: sv/pls_out_if.sv
// ============================================================================
// pls_out_if
// Billboard attribute channel: valid/ready with size, color and texture word.
// ============================================================================
interface pls_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] drawn_size;
    logic [11:0] red;
    logic [11:0] green;
    logic [11:0] blue;
    logic [10:0] alpha;
    logic [31:0] tex_word;
    logic        additive_path;

    modport source (output valid, output drawn_size, output red, output green,
                    output blue, output alpha, output tex_word,
                    output additive_path, input ready);
    modport sink   (input valid, input drawn_size, input red, input green,
                    input blue, input alpha, input tex_word,
                    input additive_path, output ready);
endinterface

// File: sv/pls_div.sv
// ============================================================================
// pls_div
// Pipelined restoring divider: quo = floor(num * 2^QW / den) for num < den.
// ============================================================================
module pls_div
    import pls_pkg::*;
#(
    parameter int DW  = PLS_DIV_W,
    parameter int QW  = PLS_Q_W,
    parameter int BPS = PLS_DIV_BPS
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int NST = QW / BPS;

    logic [DW-1:0] r_rem [NST];
    logic [DW-1:0] r_den [NST];
    logic [QW-1:0] r_quo [NST];

    genvar s;
    generate
        for (s = 0; s < NST; s++) begin : g_st
            logic [DW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic [QW-1:0] quo_in;
            logic [DW-1:0] n_rem;
            logic [QW-1:0] n_quo;

            if (s == 0) begin : g_first
                assign rem_in = i_num;
                assign den_in = i_den;
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = r_rem[s-1];
                assign den_in = r_den[s-1];
                assign quo_in = r_quo[s-1];
            end

            always_comb begin : p_step
                logic [DW:0]   tmp;
                logic [DW-1:0] rm;
                logic [QW-1:0] qq;
                rm = rem_in;
                qq = quo_in;
                for (int k = 0; k < BPS; k++) begin
                    tmp = {rm, 1'b0};
                    if (tmp >= {1'b0, den_in}) begin
                        tmp = tmp - {1'b0, den_in};
                        qq  = {qq[QW-2:0], 1'b1};
                    end else begin
                        qq  = {qq[QW-2:0], 1'b0};
                    end
                    rm = tmp[DW-1:0];
                end
                n_rem = rm;
                n_quo = qq;
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem;
                    r_den[s] <= den_in;
                    r_quo[s] <= n_quo;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[NST-1];

endmodule

// File: sv/particle_life_shader.sv
// ============================================================================
// particle_life_shader
// Per-particle color-over-life, opacity, size and flipbook word.
// ============================================================================
// Usage:
//   i_item carries one particle (age, life, birth size) per transaction;
//   o_result carries its billboard attributes, one transaction per particle,
//   in input order. Registers are written through i_cfg_we/i_cfg_idx/
//   i_cfg_data while no particle is in flight.
// Throughput: one particle per clock when not stalled. Depth: 25 register
//   stages, set by two 8-stage pipelined divider sections (life fraction,
//   then gradient weight and fade ramps) plus nine arithmetic stages;
//   o_result.valid rises when the particle reaches the last stage.
// Stall: the whole pipeline advances on one enable; when o_result.ready is
//   low with a result waiting, every stage holds, empty ones included, and
//   i_item.ready drops, so nothing is lost or repeated.
// Reset: synchronous, active low; clears all valid bits and loads the
//   register reset values (white tint, untextured, tint mode, lit path).
// ============================================================================
module particle_life_shader
    import pls_pkg::*;
#(
    parameter int DIV_BPS = PLS_DIV_BPS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [63:0]  i_cfg_data,
    pls_in_if.sink       i_item,
    pls_out_if.source    o_result
);

    localparam int NST = PLS_Q_W / DIV_BPS;
    localparam int LAT = NST * 2 + 9;

    typedef struct packed {
        logic [15:0] size;
        logic        sat;
    } t_side1;

    typedef struct packed {
        logic [15:0] size;
        logic [31:0] ca;
        logic [31:0] cb;
        logic [16:0] fi;
        logic [16:0] fo;
        logic [16:0] factor;
        logic [31:0] tex;
        logic        rin_full;
        logic        rout_full;
    } t_side2;

    // ---------------- configuration ----------------
    logic [31:0] r_base, r_sc0, r_sc1, r_sc2, r_fade_keys;
    logic [63:0] r_stop_keys;
    logic [32:0] r_tex;
    logic [1:0]  r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= PLS_RST_BASE;
            r_sc0       <= '0;
            r_sc1       <= '0;
            r_sc2       <= '0;
            r_fade_keys <= PLS_RST_FADE;
            r_stop_keys <= '0;
            r_tex       <= PLS_RST_TEX;
            r_mode      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_COLOR:  r_base      <= i_cfg_data[31:0];
                CFG_STOP_FIRST:  r_sc0       <= i_cfg_data[31:0];
                CFG_STOP_MIDDLE: r_sc1       <= i_cfg_data[31:0];
                CFG_STOP_LAST:   r_sc2       <= i_cfg_data[31:0];
                CFG_FADE_KEYS:   r_fade_keys <= i_cfg_data[31:0];
                CFG_STOP_KEYS:   r_stop_keys <= i_cfg_data;
                CFG_TEX_SETUP:   r_tex       <= i_cfg_data[32:0];
                CFG_MODE_BITS:   r_mode      <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic ramp, additive;
    assign ramp     = r_mode[0];
    assign additive = r_mode[1];

    // ---------------- pipeline control ----------------
    logic [LAT-1:0] r_vld;
    logic           en;

    assign en           = !r_vld[LAT-1] || o_result.ready;
    assign i_item.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_item.valid};
        end
    end

    // ---------------- S0: capture ----------------
    logic [15:0] r0_age, r0_life, r0_size;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_age  <= i_item.age_ticks;
            r0_life <= i_item.life_ticks;
            r0_size <= i_item.birth_size;
        end
    end

    // ---------------- life fraction divider ----------------
    logic [PLS_Q_W-1:0] q_t;
    t_side1             r_dl1 [NST];

    pls_div #(.DW(PLS_DIV_W), .QW(PLS_Q_W), .BPS(DIV_BPS)) u_div_t (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({1'b0, r0_age}),
        .i_den ({1'b0, r0_life}),
        .o_quo (q_t)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl1[0].size <= r0_size;
            r_dl1[0].sat  <= (r0_life == 16'd0) || (r0_age >= r0_life);
            for (int i = 1; i < NST; i++) r_dl1[i] <= r_dl1[i-1];
        end
    end

    // ---------------- S1: t ----------------
    logic [16:0] r1_t;
    logic [15:0] r1_size;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_t    <= r_dl1[NST-1].sat ? PLS_ONE : {1'b0, q_t};
            r1_size <= r_dl1[NST-1].size;
        end
    end

    // ---------------- S2: segment, ramps, envelope, texture ----------------
    logic [15:0] k2, k3, k4, k5, ki, ko;
    assign k2 = r_stop_keys[15:0];
    assign k3 = r_stop_keys[31:16];
    assign k4 = r_stop_keys[47:32];
    assign k5 = r_stop_keys[63:48];
    assign ki = r_fade_keys[15:0];
    assign ko = r_fade_keys[31:16];

    t_side2      n2_side;
    logic [15:0] n2_span_num, n2_span_den;

    always_comb begin : p_s2
        logic [19:0] six_t;
        logic [19:0] five_o;
        logic [31:0] fprod;
        logic [7:0]  frames, fidx;
        logic [3:0]  cols, rows;
        logic [24:0] tf;
        n2_side.size = r1_size;
        n2_side.ca   = r_sc0;
        n2_side.cb   = r_sc0;
        n2_span_num  = 16'd0;
        n2_span_den  = 16'd1;
        if (r1_t <= {1'b0, k2}) begin
            n2_side.ca = r_sc0;
            n2_side.cb = r_sc0;
        end else if (r1_t < {1'b0, k3}) begin
            n2_side.cb  = r_sc1;
            n2_span_num = r1_t[15:0] - k2;
            n2_span_den = k3 - k2;
        end else if (r1_t <= {1'b0, k4}) begin
            n2_side.ca = r_sc1;
            n2_side.cb = r_sc1;
        end else if (r1_t < {1'b0, k5}) begin
            n2_side.ca  = r_sc1;
            n2_side.cb  = r_sc2;
            n2_span_num = r1_t[15:0] - k4;
            n2_span_den = k5 - k4;
        end else begin
            n2_side.ca = r_sc2;
            n2_side.cb = r_sc2;
        end

        n2_side.rin_full  = (ki < 16'd7) || (r1_t >= {1'b0, ki});
        n2_side.rout_full = (ko > 16'd65529) || (r1_t <= {1'b0, ko});

        six_t  = 20'(r1_t) * 20'd6;
        five_o = (20'(PLS_ONE - r1_t) * 20'd5) >> 1;
        n2_side.fi = (six_t > 20'(PLS_ONE)) ? PLS_ONE : six_t[16:0];
        n2_side.fo = (five_o > 20'(PLS_ONE)) ? PLS_ONE : five_o[16:0];

        if (additive) begin
            fprod          = 32'(r1_t) * 32'd22938;
            n2_side.factor = PLS_ONE - {1'b0, fprod[31:16]};
        end else begin
            fprod          = 32'(r1_t) * 32'd52429;
            n2_side.factor = PLS_ONE + {1'b0, fprod[31:16]};
        end

        frames = (r_tex[23:16] == 8'd0) ? 8'd1 : r_tex[23:16];
        cols   = (r_tex[27:24] == 4'd0) ? 4'd1 : r_tex[27:24];
        rows   = (r_tex[31:28] == 4'd0) ? 4'd1 : r_tex[31:28];
        tf     = 25'(r1_t) * 25'(frames);
        fidx   = 8'd0;
        if (frames > 8'd1) begin
            fidx = (tf[24:16] > 9'(frames - 8'd1)) ? frames - 8'd1 : tf[23:16];
        end
        n2_side.tex = r_tex[32] ? 32'hFFFF_FFFF : {rows, cols, fidx, r_tex[15:0]};
    end

    t_side2      r2_side;
    logic [16:0] r2_span_num, r2_span_den, r2_in_num, r2_in_den;
    logic [16:0] r2_out_num, r2_out_den;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_side     <= n2_side;
            r2_span_num <= {1'b0, n2_span_num};
            r2_span_den <= {1'b0, n2_span_den};
            r2_in_num   <= r1_t;
            r2_in_den   <= {1'b0, ki};
            r2_out_num  <= PLS_ONE - r1_t;
            r2_out_den  <= PLS_ONE - {1'b0, ko};
        end
    end

    // ---------------- weight and fade ramp dividers ----------------
    logic [PLS_Q_W-1:0] q_span, q_in, q_out;
    t_side2             r_dl2 [NST];

    pls_div #(.DW(PLS_DIV_W), .QW(PLS_Q_W), .BPS(DIV_BPS)) u_div_span (
        .i_clk (i_clk), .i_en (en),
        .i_num (r2_span_num), .i_den (r2_span_den), .o_quo (q_span)
    );

    pls_div #(.DW(PLS_DIV_W), .QW(PLS_Q_W), .BPS(DIV_BPS)) u_div_in (
        .i_clk (i_clk), .i_en (en),
        .i_num (r2_in_num), .i_den (r2_in_den), .o_quo (q_in)
    );

    pls_div #(.DW(PLS_DIV_W), .QW(PLS_Q_W), .BPS(DIV_BPS)) u_div_out (
        .i_clk (i_clk), .i_en (en),
        .i_num (r2_out_num), .i_den (r2_out_den), .o_quo (q_out)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl2[0] <= r2_side;
            for (int i = 1; i < NST; i++) r_dl2[i] <= r_dl2[i-1];
        end
    end

    // ---------------- S3: weights, fade, size product ----------------
    t_side2      d2;
    logic [15:0] r3_s;
    logic [16:0] r3_rin, r3_rout, r3_fade;
    logic [32:0] r3_size_prod;
    logic [31:0] r3_ca, r3_cb, r3_tex;

    assign d2 = r_dl2[NST-1];

    always_ff @(posedge i_clk) begin : p_s3
        logic [33:0] fp;
        if (en) begin
            fp           = 34'(d2.fi) * 34'(d2.fo);
            r3_s         <= q_span;
            r3_rin       <= d2.rin_full  ? PLS_ONE : {1'b0, q_in};
            r3_rout      <= d2.rout_full ? PLS_ONE : {1'b0, q_out};
            r3_fade      <= fp[32:16];
            r3_size_prod <= 33'(d2.size) * 33'(d2.factor);
            r3_ca        <= d2.ca;
            r3_cb        <= d2.cb;
            r3_tex       <= d2.tex;
        end
    end

    // ---------------- S4: channel mix ----------------
    logic [23:0] n4_v [4];

    always_comb begin : p_mix
        logic [7:0]  a, b;
        logic [23:0] base, d;
        for (int c = 0; c < 4; c++) begin
            a    = r3_ca[8*c +: 8];
            b    = r3_cb[8*c +: 8];
            base = {a, 16'd0};
            if (b >= a) begin
                d = 24'(b - a) * 24'(r3_s);
                n4_v[c] = base + d;
            end else begin
                d = 24'(a - b) * 24'(r3_s);
                n4_v[c] = base - d;
            end
            if (!ramp) n4_v[c] = {r_base[8*c +: 8], 16'd0};
        end
    end

    logic [23:0] r4_v [4];
    logic [16:0] r4_ro, r4_fade;
    logic [15:0] r4_dsize;
    logic [31:0] r4_tex;

    always_ff @(posedge i_clk) begin : p_s4
        logic [33:0] rp;
        if (en) begin
            rp       = 34'(r3_rin) * 34'(r3_rout);
            r4_v     <= n4_v;
            r4_ro    <= rp[32:16];
            r4_fade  <= r3_fade;
            r4_dsize <= (r3_size_prod[32]) ? 16'hFFFF : r3_size_prod[31:16];
            r4_tex   <= r3_tex;
        end
    end

    // ---------------- S5: divide by 255 ----------------
    logic [16:0] r5_col [4];
    logic [16:0] r5_ro, r5_fade;
    logic [15:0] r5_dsize;
    logic [31:0] r5_tex;

    always_ff @(posedge i_clk) begin : p_s5
        logic [48:0] p;
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                p = 49'(r4_v[c]) * 49'(PLS_RCP255);
                r5_col[c] <= p[48:32];
            end
            r5_ro    <= r4_ro;
            r5_fade  <= r4_fade;
            r5_dsize <= r4_dsize;
            r5_tex   <= r4_tex;
        end
    end

    // ---------------- S6: ramp alpha ----------------
    logic [16:0] r6_col [3];
    logic [16:0] r6_a3, r6_fade;
    logic [15:0] r6_dsize;
    logic [31:0] r6_tex;

    always_ff @(posedge i_clk) begin : p_s6
        logic [33:0] p;
        if (en) begin
            p = 34'(r5_col[3]) * 34'(r5_ro);
            r6_a3 <= ramp ? p[32:16] : r5_col[3];
            for (int c = 0; c < 3; c++) r6_col[c] <= r5_col[c];
            r6_fade  <= r5_fade;
            r6_dsize <= r5_dsize;
            r6_tex   <= r5_tex;
        end
    end

    // ---------------- S7: color products ----------------
    logic [33:0] r7_m [3];
    logic [33:0] r7_m3;
    logic [16:0] r7_col [3];
    logic [16:0] r7_a3;
    logic [15:0] r7_dsize;
    logic [31:0] r7_tex;

    always_ff @(posedge i_clk) begin : p_s7
        logic [16:0] sc;
        if (en) begin
            sc = ramp ? r6_a3 : r6_fade;
            for (int c = 0; c < 3; c++) r7_m[c] <= 34'(r6_col[c]) * 34'(sc);
            r7_m3    <= 34'(r6_a3) * 34'(r6_fade);
            r7_col   <= r6_col;
            r7_a3    <= r6_a3;
            r7_dsize <= r6_dsize;
            r7_tex   <= r6_tex;
        end
    end

    // ---------------- S8: output format ----------------
    logic [11:0] r8_rgb [3];
    logic [10:0] r8_alpha;
    logic [15:0] r8_dsize;
    logic [31:0] r8_tex;
    logic        r8_add;

    always_ff @(posedge i_clk) begin : p_s8
        logic [35:0] x;
        logic [35:0] xr;
        logic [16:0] q10;
        logic [16:0] al;
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                x  = ramp ? (36'(r7_m[c]) + {r7_m[c], 1'b0}) : 36'(r7_m[c]);
                xr = (x + 36'(1 << 21)) >> 22;
                q10 = (r7_col[c] + 17'd32) >> 6;
                if (additive) begin
                    r8_rgb[c] <= (xr > 36'd4095) ? 12'hFFF : xr[11:0];
                end else begin
                    r8_rgb[c] <= (q10 > 17'd4095) ? 12'hFFF : q10[11:0];
                end
            end
            al = ramp ? r7_a3 : r7_m3[32:16];
            al = (al + 17'd32) >> 6;
            r8_alpha <= additive ? 11'd1024 : al[10:0];
            r8_dsize <= r7_dsize;
            r8_tex   <= r7_tex;
            r8_add   <= additive;
        end
    end

    assign o_result.valid         = r_vld[LAT-1];
    assign o_result.drawn_size    = r8_dsize;
    assign o_result.red           = r8_rgb[0];
    assign o_result.green         = r8_rgb[1];
    assign o_result.blue          = r8_rgb[2];
    assign o_result.alpha         = r8_alpha;
    assign o_result.tex_word      = r8_tex;
    assign o_result.additive_path = r8_add;

endmodule

// File: verif/tb_top.sv
// ============================================================================
// tb_top
// Particle life shader: directed table of particles and register settings,
// then random traffic checked against a fixed-point model of the shader.
// ============================================================================
module tb_top;
    import pls_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT   = 25;
    localparam int STALL_MAX  = 4000;
    localparam int N_RANDOM   = 1150;

    typedef struct packed {
        logic [15:0] drawn_size;
        logic [11:0] red;
        logic [11:0] green;
        logic [11:0] blue;
        logic [10:0] alpha;
        logic [31:0] tex_word;
        logic        additive_path;
    } t_attr;

    typedef struct {
        logic [15:0] age;
        logic [15:0] life;
        logic [15:0] bsize;
        bit          typed;   // expected value written in the row
        t_attr       attr;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;

    pls_in_if  item_ch ();
    pls_out_if attr_ch ();

    particle_life_shader dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_item    (item_ch.sink),
        .o_result  (attr_ch.source)
    );

    always #4 i_clk = ~i_clk;

    // shadow registers
    logic [31:0] m_base, m_first, m_middle, m_last, m_fade;
    logic [63:0] m_keys;
    logic [32:0] m_tex;
    logic [1:0]  m_mode;

    t_attr attr_q[$];
    int    n_bad = 0;
    int    idle_cyc = 0;
    bit    timed_out = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;

    initial begin
        item_ch.valid = 1'b0;
        item_ch.age_ticks = '0;
        item_ch.life_ticks = 16'd1;
        item_ch.birth_size = '0;
        attr_ch.ready = 1'b0;
    end

    function automatic longint unsigned lo_min(longint unsigned a, longint unsigned b);
        return a < b ? a : b;
    endfunction

    function automatic longint unsigned span_w(longint unsigned t, longint unsigned a,
                                               longint unsigned b);
        longint unsigned num;
        if (b <= a) return 65536;
        num = t > a ? t - a : 0;
        if (num > b - a) num = b - a;
        return (num * 65536) / (b - a);
    endfunction

    function automatic longint unsigned blend_ch(longint unsigned ca, longint unsigned cb,
                                                 longint unsigned s);
        longint unsigned v;
        v = ca * 65536;
        if (cb >= ca) v += (cb - ca) * s;
        else v -= (ca - cb) * s;
        return v / 255;
    endfunction

    function automatic longint unsigned hdr_q10(longint unsigned q32);
        return lo_min((q32 + (64'd1 << 21)) >> 22, 4095);
    endfunction

    function automatic t_attr shade_particle(logic [15:0] age, logic [15:0] life,
                                             logic [15:0] bsize);
        t_attr r;
        longint unsigned t, fi, fo, fade, factor, ki, ko, s, rin, rout;
        longint unsigned frames, cols, rows, fidx;
        longint unsigned col[4], rgb[3];
        logic [31:0] ca, cb;
        bit ramp_on, additive;
        longint unsigned k2, k3, k4, k5;
        ramp_on = m_mode[0];
        additive = m_mode[1];
        if (life == 0 || age >= life) t = 65536;
        else t = (64'(age) * 65536) / life;
        fi = lo_min(6 * t, 65536);
        fo = lo_min((5 * (65536 - t)) >> 1, 65536);
        fade = (fi * fo) >> 16;
        if (ramp_on) begin
            k2 = m_keys[15:0]; k3 = m_keys[31:16];
            k4 = m_keys[47:32]; k5 = m_keys[63:48];
            ki = m_fade[15:0]; ko = m_fade[31:16];
            if (t <= k2) begin ca = m_first; cb = ca; s = 0; end
            else if (t < k3) begin ca = m_first; cb = m_middle; s = span_w(t, k2, k3); end
            else if (t <= k4) begin ca = m_middle; cb = ca; s = 0; end
            else if (t < k5) begin ca = m_middle; cb = m_last; s = span_w(t, k4, k5); end
            else begin ca = m_last; cb = ca; s = 0; end
            for (int c = 0; c < 4; c++)
                col[c] = blend_ch(ca[c*8 +: 8], cb[c*8 +: 8], s);
            rin = ki >= 7 ? lo_min((t * 65536) / ki, 65536) : 65536;
            rout = ko <= 65529 ? lo_min(((65536 - t) * 65536) / (65536 - ko), 65536) : 65536;
            col[3] = (col[3] * ((rin * rout) >> 16)) >> 16;
        end else begin
            for (int c = 0; c < 4; c++) col[c] = (64'(m_base[c*8 +: 8]) * 65536) / 255;
        end
        if (additive) begin
            factor = 65536 - ((22938 * t) >> 16);
            for (int c = 0; c < 3; c++)
                rgb[c] = ramp_on ? hdr_q10(3 * col[c] * col[3]) : hdr_q10(col[c] * fade);
            r.alpha = 11'd1024;
        end else begin
            factor = 65536 + ((52429 * t) >> 16);
            for (int c = 0; c < 3; c++) rgb[c] = lo_min((col[c] + 32) >> 6, 4095);
            r.alpha = ramp_on ? 11'((col[3] + 32) >> 6)
                              : 11'((((col[3] * fade) >> 16) + 32) >> 6);
        end
        r.drawn_size = 16'(lo_min((64'(bsize) * factor) >> 16, 65535));
        r.red = 12'(rgb[0]);
        r.green = 12'(rgb[1]);
        r.blue = 12'(rgb[2]);
        if (m_tex[32]) begin
            r.tex_word = 32'hFFFF_FFFF;
        end else begin
            frames = m_tex[23:16]; cols = m_tex[27:24]; rows = m_tex[31:28];
            fidx = 0;
            if (frames == 0) frames = 1;
            if (cols == 0) cols = 1;
            if (rows == 0) rows = 1;
            if (frames > 1) fidx = lo_min((t * frames) >> 16, frames - 1);
            r.tex_word = {4'(rows), 4'(cols), 8'(fidx), m_tex[15:0]};
        end
        r.additive_path = additive;
        return r;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BASE_COLOR:  m_base = val[31:0];
            CFG_STOP_FIRST:  m_first = val[31:0];
            CFG_STOP_MIDDLE: m_middle = val[31:0];
            CFG_STOP_LAST:   m_last = val[31:0];
            CFG_FADE_KEYS:   m_fade = val[31:0];
            CFG_STOP_KEYS:   m_keys = val;
            CFG_TEX_SETUP:   m_tex = val[32:0];
            CFG_MODE_BITS:   m_mode = val[1:0];
            default: ;
        endcase
    endtask

    task automatic drain_results();
        while (attr_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 5) @(posedge i_clk);
    endtask

    task automatic send_particle(logic [15:0] age, logic [15:0] life, logic [15:0] bsize,
                                 bit typed, t_attr want);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.age_ticks <= age;
        item_ch.life_ticks <= life;
        item_ch.birth_size <= bsize;
        do @(posedge i_clk); while (!item_ch.ready);
        attr_q = {attr_q, (typed ? want : shade_particle(age, life, bsize))};
    endtask

    task automatic stop_sending();
        item_ch.valid <= 1'b0;
    endtask

    task automatic random_regs(bit extreme);
        write_reg(CFG_BASE_COLOR, extreme ? 64'(32'hFFFF_FFFF) : 64'($urandom));
        write_reg(CFG_STOP_FIRST, extreme ? 64'd0 : 64'($urandom));
        write_reg(CFG_STOP_MIDDLE, extreme ? 64'(32'hFFFF_FFFF) : 64'($urandom));
        write_reg(CFG_STOP_LAST, 64'($urandom));
        write_reg(CFG_FADE_KEYS, $urandom_range(1, 0) ? 64'($urandom)
                  : 64'({16'($urandom_range(65535, 65520)), 16'($urandom_range(10, 0))}));
        begin
            logic [15:0] k[4];
            for (int j = 0; j < 4; j++) k[j] = 16'($urandom);
            k.sort();
            if ($urandom_range(3, 0) == 0) k[1] = k[0];  // degenerate span
            write_reg(CFG_STOP_KEYS, $urandom_range(4, 0) == 0
                      ? {$urandom, $urandom} : {k[3], k[2], k[1], k[0]});
        end
        write_reg(CFG_TEX_SETUP, {31'd0, 1'($urandom_range(3, 0) == 0), $urandom});
        write_reg(CFG_MODE_BITS, 64'($urandom_range(3, 0)));
    endtask

    // receiver, checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (attr_ch.valid && attr_ch.ready) begin
                t_attr got, want;
                got = '{attr_ch.drawn_size, attr_ch.red, attr_ch.green, attr_ch.blue,
                        attr_ch.alpha, attr_ch.tex_word, attr_ch.additive_path};
                if (attr_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) $display("ERROR: unexpected transaction %p", got);
                end else begin
                    want = attr_q.pop_front();
                    if (got !== want) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("ERROR: mismatch expected %p actual %p", want, got);
                    end
                end
            end
            attr_ch.ready <= !(recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct);
            if ((attr_ch.valid && attr_ch.ready) || (item_ch.valid && item_ch.ready))
                idle_cyc <= 0;
            else
                idle_cyc <= idle_cyc + 1;
            if (idle_cyc > STALL_MAX && !timed_out) begin
                timed_out = 1;
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    t_row rows_q[$];

    function automatic t_row mk(logic [15:0] a, logic [15:0] l, logic [15:0] b);
        t_row r;
        r.age = a; r.life = l; r.bsize = b; r.typed = 0; r.attr = '0;
        return r;
    endfunction

    function automatic t_row mk_typed(logic [15:0] a, logic [15:0] l, logic [15:0] b,
                                      t_attr want);
        t_row r;
        r = mk(a, l, b);
        r.typed = 1; r.attr = want;
        return r;
    endfunction

    function automatic void add_row(t_row r);
        rows_q = {rows_q, r};
    endfunction

    initial begin
        int phase;
        logic [15:0] life;
        m_base = PLS_RST_BASE; m_first = '0; m_middle = '0; m_last = '0;
        m_fade = PLS_RST_FADE; m_keys = '0; m_tex = PLS_RST_TEX; m_mode = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: tint white, lit, untextured; t=0 means fade 0
        add_row(mk_typed(16'd0, 16'd100, 16'h0100,
                '{16'h0100, 12'd1024, 12'd1024, 12'd1024, 11'd0, 32'hFFFF_FFFF, 1'b0}));
        // age past life: t=1, fade 0, size * 1.8
        add_row(mk_typed(16'hFFFF, 16'd1, 16'h0100,
                '{16'h01CC, 12'd1024, 12'd1024, 12'd1024, 11'd0, 32'hFFFF_FFFF, 1'b0}));
        add_row(mk(16'hFFFF, 16'hFFFF, 16'hFFFF));   // size saturates
        add_row(mk(16'hFFFE, 16'hFFFF, 16'hFFFF));
        add_row(mk(16'd1, 16'hFFFF, 16'hAAAA));
        add_row(mk(16'd10, 16'd40, 16'h5555));
        add_row(mk(16'd0, 16'd1, 16'd0));
        foreach (rows_q[i]) send_particle(rows_q[i].age, rows_q[i].life, rows_q[i].bsize,
                                          rows_q[i].typed, rows_q[i].attr);
        stop_sending();
        drain_results();

        // additive tint: alpha always 1
        write_reg(CFG_MODE_BITS, 64'd2);
        send_particle(16'd0, 16'd50, 16'h0100, 1,
                      '{16'h0100, 12'd0, 12'd0, 12'd0, 11'd1024, 32'hFFFF_FFFF, 1'b1});
        send_particle(16'd25, 16'd50, 16'hFFFF, 0, '0);
        stop_sending();
        drain_results();
        // textured, frames/cols/rows zero act as one
        write_reg(CFG_TEX_SETUP, 64'h0000_0000_0000_1234);
        send_particle(16'd7, 16'd9, 16'h0800, 0, '0);
        stop_sending();
        drain_results();
        write_reg(CFG_TEX_SETUP, 64'h0000_0000_FFFF_FFFF);
        send_particle(16'd9, 16'd9, 16'h0800, 0, '0);
        send_particle(16'd3, 16'd9, 16'h0800, 0, '0);
        stop_sending();
        drain_results();

        // ramp, extreme stops, degenerate spans, fade keys at extremes
        for (int m = 0; m < 4; m++) begin
            random_regs(1);
            write_reg(CFG_MODE_BITS, 64'(m));
            write_reg(CFG_STOP_KEYS, m[0] ? 64'h0000_8000_8000_0000 : 64'hFFFF_C000_4000_1000);
            write_reg(CFG_FADE_KEYS, m[1] ? 64'h0000_FFFA_0000_0006 : 64'h0000_0000_0000_FFFF);
            for (int a = 0; a <= 4; a++) send_particle(16'(a * 4), 16'd16, 16'hFFFF, 0, '0);
            stop_sending();
            drain_results();
        end

        // random phases
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 12 : (phase == 1 ? 83 : 0);
            recv_idle_pct = phase == 0 ? 83 : (phase == 1 ? 12 : 0);
            for (int blk = 0; blk < 6; blk++) begin
                random_regs(0);
                for (int n = 0; n < N_RANDOM / 18; n++) begin
                    life = $urandom_range(4, 0) == 0 ? 16'($urandom)
                                                     : 16'($urandom_range(300, 1));
                    send_particle($urandom_range(5, 0) == 0 ? 16'($urandom)
                                                            : 16'($urandom_range(life, 0)),
                                  life, 16'($urandom), 0, '0);
                end
                stop_sending();
                drain_results();
            end
        end

        drain_results();
        if (n_bad == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
